>>> sv/vtsc_pkg.sv
package vtsc_pkg;

  // Item command codes
  typedef enum logic [2:0] {
    CMD_TUNE_DOWN = 3'd0,
    CMD_TUNE_UP   = 3'd1,
    CMD_CLAMP     = 3'd2,
    CMD_STEP_UP   = 3'd3,
    CMD_STEP_DOWN = 3'd4
  } cmd_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_MAX_FREQ    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_FREQ    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_UPPER_CLAMP = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_LOWER_CLAMP = 2'd3;

  localparam logic [31:0] MaxFreqRst    = 32'd10150000;
  localparam logic [31:0] MinFreqRst    = 32'd10100000;
  localparam logic [31:0] UpperClampRst = 32'd10150000;
  localparam logic [31:0] LowerClampRst = 32'd10100000;

  // Step list
  localparam logic [2:0] NumSteps     = 3'd6;
  localparam logic [2:0] StepIdxRst   = 3'd2;
  localparam logic [2:0] StepIdxFirst = 3'd0;
  localparam logic [2:0] StepIdxDown  = 3'd4;

  localparam int unsigned StepW = 10;
  localparam int unsigned OutDataW = 48;

  typedef struct packed {
    logic [31:0] max_freq;
    logic [31:0] min_freq;
    logic [31:0] upper_clamp;
    logic [31:0] lower_clamp;
  } cfg_t;

  typedef struct packed {
    logic             saved_flag;
    logic             changed_flag;
    logic [StepW-1:0] step_hz;
    logic [31:0]      new_freq;
  } res_t;

  // Step size in Hz for an index; out-of-range indexes fall back to the reset step
  function automatic logic [StepW-1:0] step_of(input logic [2:0] idx);
    logic [StepW-1:0] s;
    unique case (idx)
      3'd0:    s = 10'd1;
      3'd1:    s = 10'd10;
      3'd2:    s = 10'd50;
      3'd3:    s = 10'd100;
      3'd4:    s = 10'd500;
      3'd5:    s = 10'd1000;
      default: s = 10'd50;
    endcase
    return s;
  endfunction

endpackage

>>> sv/vtsc_cfg_regs.sv
module vtsc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vtsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  output vtsc_pkg::cfg_t                cfg_o
);
  import vtsc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Pick the register to update
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_FREQ:    cfg_d.max_freq    = cfg_wdata_i;
        REG_MIN_FREQ:    cfg_d.min_freq    = cfg_wdata_i;
        REG_UPPER_CLAMP: cfg_d.upper_clamp = cfg_wdata_i;
        REG_LOWER_CLAMP: cfg_d.lower_clamp = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_freq    <= MaxFreqRst;
      cfg_q.min_freq    <= MinFreqRst;
      cfg_q.upper_clamp <= UpperClampRst;
      cfg_q.lower_clamp <= LowerClampRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/vtsc_core.sv
module vtsc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  input  logic [2:0]     cmd_i,
  input  logic [31:0]    freq_i,
  input  vtsc_pkg::cfg_t cfg_i,
  output vtsc_pkg::res_t res_o
);
  import vtsc_pkg::*;

  logic [2:0]       step_idx_q, step_idx_d;
  logic             changed_q, changed_d;
  logic             saved_q, saved_d;
  logic [2:0]       idx_cur;
  logic [StepW-1:0] step_cur;
  logic [31:0]      adj_freq;
  logic [31:0]      out_freq;

  // Sanitise the index and look up the present step
  assign idx_cur  = (step_idx_q >= NumSteps) ? StepIdxRst : step_idx_q;
  assign step_cur = step_of(idx_cur);

  // Adjust, then clamp with the upper bound tested first
  always_comb begin
    step_idx_d = idx_cur;
    changed_d  = changed_q;
    saved_d    = saved_q;
    adj_freq   = freq_i;
    out_freq   = freq_i;
    unique case (cmd_i)
      CMD_TUNE_DOWN, CMD_TUNE_UP, CMD_CLAMP: begin
        if (cmd_i == CMD_TUNE_DOWN) begin
          adj_freq = freq_i - {22'd0, step_cur};
        end else if (cmd_i == CMD_TUNE_UP) begin
          adj_freq = freq_i + {22'd0, step_cur};
        end
        priority if (adj_freq > cfg_i.max_freq) begin
          out_freq = cfg_i.upper_clamp;
        end else if (adj_freq < cfg_i.min_freq) begin
          out_freq = cfg_i.lower_clamp;
        end else begin
          out_freq = adj_freq;
        end
        changed_d = 1'b1;
        saved_d   = 1'b0;
      end
      CMD_STEP_UP: begin
        step_idx_d = (idx_cur + 3'd1 >= NumSteps) ? StepIdxFirst : idx_cur + 3'd1;
      end
      CMD_STEP_DOWN: begin
        step_idx_d = (idx_cur == StepIdxFirst) ? StepIdxDown : idx_cur - 3'd1;
      end
      default: begin
        step_idx_d = idx_cur;
      end
    endcase
  end

  // Commit state as the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_idx_q <= StepIdxRst;
      changed_q  <= 1'b0;
      saved_q    <= 1'b1;
    end else if (advance_i) begin
      step_idx_q <= step_idx_d;
      changed_q  <= changed_d;
      saved_q    <= saved_d;
    end
  end

  assign res_o.new_freq     = out_freq;
  assign res_o.step_hz      = step_of(step_idx_d);
  assign res_o.changed_flag = changed_d;
  assign res_o.saved_flag   = saved_d;

endmodule

>>> sv/vfo_tuning_step_control.sv
// Items pass the input register, then the result register. Throughput: one
// item per cycle while results are taken; the input register refills while a
// result waits, so the step/flag state feeds the next item without a bubble.
// Reset: asynchronous, active low; clears both pipeline valids, sets the
// step to 50 Hz, changed flag 0, saved flag 1, and loads register defaults.
module vfo_tuning_step_control (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [vtsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // [31:0] current_freq
  input  logic [2:0]                    s_axis_tuser,  // [2:0] command
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] new_freq, [41:32] step_hz, [42] changed_flag, [43] saved_flag, rest 0
  output logic [vtsc_pkg::OutDataW-1:0] m_axis_tdata
);
  import vtsc_pkg::*;

  cfg_t        cfg;
  res_t        res;
  res_t        res_q;
  logic        in_valid_q, in_valid_d;
  logic [2:0]  cmd_q;
  logic [31:0] freq_q;
  logic        out_valid_q, out_valid_d;
  logic        out_take;
  logic        advance;
  logic        in_fire;

  vtsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  vtsc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .cmd_i     (cmd_q),
    .freq_i    (freq_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // Handshake control
  assign out_take      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_take;
  assign s_axis_tready = !in_valid_q || out_take;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the item, then hold the result until taken
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= s_axis_tuser;
      freq_q <= s_axis_tdata;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(res_t)){1'b0}}, res_q};

  // The reported step is always one of the six list values
  a_step_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[41:32] == 10'd1 || m_axis_tdata[41:32] == 10'd10 ||
                       m_axis_tdata[41:32] == 10'd50 || m_axis_tdata[41:32] == 10'd100 ||
                       m_axis_tdata[41:32] == 10'd500 || m_axis_tdata[41:32] == 10'd1000))
    else $error("step_hz outside step list");

  // Tune and clamp items leave changed set and saved clear
  a_tune_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (cmd_q == CMD_TUNE_DOWN || cmd_q == CMD_TUNE_UP || cmd_q == CMD_CLAMP))
    |=> (m_axis_tdata[42] && !m_axis_tdata[43]))
    else $error("flags wrong after tune item");

  // Step items echo the frequency
  a_step_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (cmd_q == CMD_STEP_UP || cmd_q == CMD_STEP_DOWN))
    |=> (m_axis_tdata[31:0] == $past(freq_q)))
    else $error("step item changed frequency");

  // A held item stays put while the result side is stalled
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_take) |=> (in_valid_q && $stable(cmd_q) && $stable(freq_q)))
    else $error("input item lost during stall");

endmodule

>>> bench/tuning_result_checker.sv
`timescale 1ns / 100ps

module tuning_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vtsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [31:0]                   s_tdata_i,
  input  logic [2:0]                    s_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [vtsc_pkg::OutDataW-1:0] m_tdata_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import vtsc_pkg::*;

  // Own copy of the limits and of the step/flag state
  logic [31:0]      lim_max;
  logic [31:0]      lim_min;
  logic [31:0]      clamp_hi;
  logic [31:0]      clamp_lo;
  logic [2:0]       step_idx;
  logic             changed;
  logic             saved;
  logic [StepW-1:0] step_hz_tbl [0:5];

  res_t             pending_tunings [$];
  res_t             want;
  res_t             got;
  logic [3:0]       got_pad;

  initial begin
    step_hz_tbl[0] = 10'd1;
    step_hz_tbl[1] = 10'd10;
    step_hz_tbl[2] = 10'd50;
    step_hz_tbl[3] = 10'd100;
    step_hz_tbl[4] = 10'd500;
    step_hz_tbl[5] = 10'd1000;
  end

  // Advance the state by one command and report the result it gives
  function automatic res_t apply_command(input logic [2:0] cmd, input logic [31:0] freq);
    res_t        r;
    logic [31:0] f;
    f = freq;
    case (cmd)
      CMD_TUNE_DOWN, CMD_TUNE_UP, CMD_CLAMP: begin
        if (cmd == CMD_TUNE_DOWN) begin
          f = f - {22'd0, step_hz_tbl[step_idx]};
        end else if (cmd == CMD_TUNE_UP) begin
          f = f + {22'd0, step_hz_tbl[step_idx]};
        end
        // upper test wins; lower test only when not above
        if (f > lim_max) begin
          f = clamp_hi;
        end else if (f < lim_min) begin
          f = clamp_lo;
        end
        changed = 1'b1;
        saved   = 1'b0;
      end
      CMD_STEP_UP: begin
        step_idx = (step_idx == NumSteps - 3'd1) ? StepIdxFirst : step_idx + 3'd1;
      end
      CMD_STEP_DOWN: begin
        // from 1 Hz the step skips 1000 and lands on 500
        step_idx = (step_idx == StepIdxFirst) ? StepIdxDown : step_idx - 3'd1;
      end
      default: begin
      end
    endcase
    r.new_freq     = f;
    r.step_hz      = step_hz_tbl[step_idx];
    r.changed_flag = changed;
    r.saved_flag   = saved;
    return r;
  endfunction

  // Track writes, predict on each input item, compare on each result item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_max      = MaxFreqRst;
      lim_min      = MinFreqRst;
      clamp_hi     = UpperClampRst;
      clamp_lo     = LowerClampRst;
      step_idx     = StepIdxRst;
      changed      = 1'b0;
      saved        = 1'b1;
      fail_count_o = 0;
      pending_tunings.delete();
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_FREQ:    lim_max  = cfg_wdata_i;
          REG_MIN_FREQ:    lim_min  = cfg_wdata_i;
          REG_UPPER_CLAMP: clamp_hi = cfg_wdata_i;
          REG_LOWER_CLAMP: clamp_lo = cfg_wdata_i;
          default: begin
          end
        endcase
      end

      if (m_tvalid_i && m_tready_i) begin
        got     = m_tdata_i[43:0];
        got_pad = m_tdata_i[47:44];
        if (pending_tunings.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: result item with none outstanding: freq %h step %0d chg %b sav %b",
                     $realtime, got.new_freq, got.step_hz, got.changed_flag, got.saved_flag);
          end
          fail_count_o++;
        end else begin
          want = pending_tunings.pop_front();
          if (got.new_freq != want.new_freq || got.step_hz != want.step_hz ||
              got.changed_flag != want.changed_flag || got.saved_flag != want.saved_flag ||
              got_pad != 4'd0) begin
            if (fail_count_o < 10) begin
              $display("%0t: mismatch: expected freq %h step %0d chg %b sav %b pad 0",
                       $realtime, want.new_freq, want.step_hz, want.changed_flag,
                       want.saved_flag);
              $display("%0t:           actual   freq %h step %0d chg %b sav %b pad %h",
                       $realtime, got.new_freq, got.step_hz, got.changed_flag,
                       got.saved_flag, got_pad);
            end
            fail_count_o++;
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        pending_tunings.push_back(apply_command(s_tuser_i, s_tdata_i));
      end
      pending_o = pending_tunings.size();
    end
  end

endmodule

>>> bench/vfo_tuning_step_control_tb.sv
`timescale 1ns / 100ps

module vfo_tuning_step_control_tb;
  import vtsc_pkg::*;

  logic                 clk_i     = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx   = REG_MAX_FREQ;
  logic [31:0]          cfg_wdata = 32'd0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata   = 32'd0;
  logic [2:0]           s_tuser   = 3'd0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OutDataW-1:0]  m_tdata;

  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          items_sent = 0;
  logic                 calm       = 1'b0;
  logic                 hold_off   = 1'b0;
  logic [31:0]          cur_max    = MaxFreqRst;
  logic [31:0]          cur_min    = MinFreqRst;

  vfo_tuning_step_control DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  tuning_result_checker u_result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // Result side: drop ready at random, or hold it low during the hold-off
  always @(negedge clk_i) begin
    m_tready <= !hold_off && (calm || $urandom_range(0, 99) >= 8);
  end

  // Hold off the result side for a long stretch so the block backs up
  initial begin
    wait (items_sent >= 750);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Give up after a generous fixed time
  initial begin
    #2_000_000;
    $display("FAIL vfo_tuning_step_control");
    $finish;
  end

  // Offer one item, with a random gap ahead of it, and wait until taken
  task automatic offer_command(input logic [2:0] cmd, input logic [31:0] freq);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= freq;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Stop offering and wait until every result item is back
  task automatic drain;
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Load all four limit registers while the block is idle
  task automatic set_limits(input logic [31:0] mx, input logic [31:0] mn,
                            input logic [31:0] hi, input logic [31:0] lo);
    drain();
    @(negedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= REG_MAX_FREQ; cfg_wdata <= mx;
    @(negedge clk_i);
    cfg_idx <= REG_MIN_FREQ; cfg_wdata <= mn;
    @(negedge clk_i);
    cfg_idx <= REG_UPPER_CLAMP; cfg_wdata <= hi;
    @(negedge clk_i);
    cfg_idx <= REG_LOWER_CLAMP; cfg_wdata <= lo;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cur_max = mx;
    cur_min = mn;
  endtask

  // Aim frequencies at the limits and the wrap points as well as anywhere
  function automatic logic [31:0] pick_freq();
    logic [31:0] jitter;
    jitter = $urandom_range(0, 2200) - 1100;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4:    return cur_max + jitter;
      5, 6:    return cur_min + jitter;
      7:       return $urandom_range(0, 1500);
      8:       return 32'hFFFF_FFFF - $urandom_range(0, 1500);
      default: return cur_min + $urandom_range(0, 60000);
    endcase
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned roll;
    logic [2:0]  cmd;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 25)      cmd = CMD_TUNE_UP;
      else if (roll < 50) cmd = CMD_TUNE_DOWN;
      else if (roll < 62) cmd = CMD_CLAMP;
      else if (roll < 76) cmd = CMD_STEP_UP;
      else if (roll < 90) cmd = CMD_STEP_DOWN;
      else                cmd = 3'($urandom_range(5, 7));
      offer_command(cmd, pick_freq());
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_n <= 1'b1;

    // Clamp edges with the reset limits
    offer_command(CMD_CLAMP, 32'd10120000);
    offer_command(CMD_CLAMP, 32'd10150000);
    offer_command(CMD_CLAMP, 32'd10150001);
    offer_command(CMD_CLAMP, 32'd10100000);
    offer_command(CMD_CLAMP, 32'd10099999);
    offer_command(CMD_TUNE_UP, 32'd10149950);
    offer_command(CMD_TUNE_UP, 32'd10149951);
    offer_command(CMD_TUNE_DOWN, 32'd10100050);
    // Wrap below zero and above the top
    offer_command(CMD_TUNE_DOWN, 32'h0000_0000);
    offer_command(CMD_TUNE_UP, 32'hFFFF_FFFF);
    // Walk the step list through both wrap points
    offer_command(CMD_STEP_DOWN, 32'h0000_0000);
    offer_command(CMD_STEP_DOWN, 32'hFFFF_FFFF);
    offer_command(CMD_STEP_DOWN, 32'h5555_5555);
    offer_command(CMD_STEP_UP, 32'hAAAA_AAAA);
    offer_command(CMD_TUNE_UP, 32'd10120000);
    offer_command(CMD_STEP_DOWN, 32'd10120000);
    offer_command(CMD_STEP_UP, 32'd10120000);
    offer_command(CMD_STEP_UP, 32'd10120000);
    offer_command(CMD_TUNE_DOWN, 32'h0000_0000);
    // Unused command codes leave the state alone
    offer_command(3'd5, 32'hFFFF_FFFF);
    offer_command(3'd6, 32'h0000_0000);
    offer_command(3'd7, 32'h1234_5678);
    offer_command(CMD_STEP_UP, 32'd10110000);
    offer_command(CMD_STEP_UP, 32'd10110000);

    run_random(280);

    // Limits wide open, no idling on either side: wrap shows through
    set_limits(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    calm = 1'b1;
    run_random(250);
    calm = 1'b0;

    // Limits inverted: everything gets clamped
    set_limits(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    run_random(150);

    // Arbitrary limits, possibly crossed
    set_limits($urandom, $urandom, $urandom, $urandom);
    run_random(250);

    // Narrow window around a random centre
    cur_min = $urandom;
    set_limits(cur_min + 32'd3000, cur_min, $urandom, $urandom);
    run_random(250);

    drain();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS vfo_tuning_step_control");
    end else begin
      $display("FAIL vfo_tuning_step_control");
    end
    $finish;
  end

endmodule
